FILE: hw/rtl/qpd_pkg.sv
// Shared types, constants and the hex digit helper for the quoted-printable decoder.
// No dependencies; used by qpd_step and quoted_printable_decoder.
package qpd_pkg;

    localparam logic [1:0] PH_TEXT = 2'd0;
    localparam logic [1:0] PH_HI   = 2'd1;
    localparam logic [1:0] PH_LO   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_LONG  = 2'd1;
    localparam logic [1:0] ST_INVAL = 2'd2;

    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TILDE  = 8'h7E;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    typedef struct packed {
        logic [1:0]  phase;
        logic [3:0]  high_nibble;
        logic [15:0] out_count;
        logic [1:0]  error_code;
    } dec_state_t;

    typedef struct packed {
        logic        emit;
        logic [7:0]  out_byte;
        logic        is_final;
        logic [1:0]  status;
        logic [15:0] out_length;
    } dec_result_t;

    // bit 4: digit is valid, bits 3:0: its value
    function automatic logic [4:0] hex_digit(input logic [7:0] ch);
        logic [4:0] r;
        r = 5'd0;
        if (ch >= 8'h30 && ch <= 8'h39)
            r = {1'b1, ch[3:0]};
        else if ((ch >= 8'h61 && ch <= 8'h66) || (ch >= 8'h41 && ch <= 8'h46))
            r = {1'b1, ch[3:0] + 4'd9};
        return r;
    endfunction

endpackage

FILE: hw/rtl/qpd_step.sv
// Next-state and result logic for one character of the decoder.
// Depends on qpd_pkg.
module qpd_step (
    input  qpd_pkg::dec_state_t  cur,
    input  logic [7:0]           in_byte,
    input  logic                 is_end,
    input  logic [15:0]          capacity,
    output qpd_pkg::dec_state_t  nxt,
    output qpd_pkg::dec_result_t res
);

    logic [4:0] hex;

    assign hex = qpd_pkg::hex_digit(in_byte);

    always_comb
    begin
        nxt = cur;
        res = '0;
        if (is_end)
        begin
            res.emit       = 1'b1;
            res.is_final   = 1'b1;
            res.out_length = cur.out_count;
            if (cur.error_code == qpd_pkg::ST_OK && cur.phase != qpd_pkg::PH_TEXT)
                res.status = qpd_pkg::ST_INVAL;
            else
                res.status = cur.error_code;
            nxt = '0;
        end
        else if (cur.error_code == qpd_pkg::ST_OK)
        begin
            case (cur.phase)
                qpd_pkg::PH_HI:
                begin
                    if (hex[4])
                    begin
                        nxt.high_nibble = hex[3:0];
                        nxt.phase       = qpd_pkg::PH_LO;
                    end
                    else
                    begin
                        nxt.error_code = qpd_pkg::ST_INVAL;
                        nxt.phase      = qpd_pkg::PH_TEXT;
                    end
                end
                qpd_pkg::PH_LO:
                begin
                    nxt.phase = qpd_pkg::PH_TEXT;
                    if (hex[4])
                    begin
                        res.emit      = 1'b1;
                        res.out_byte  = {cur.high_nibble, hex[3:0]};
                        nxt.out_count = cur.out_count + 16'd1;
                    end
                    else
                        nxt.error_code = qpd_pkg::ST_INVAL;
                end
                default:
                begin
                    nxt.phase = qpd_pkg::PH_TEXT;
                    if (cur.out_count >= capacity)
                        nxt.error_code = qpd_pkg::ST_LONG;
                    else if (in_byte == qpd_pkg::CH_EQUALS)
                        nxt.phase = qpd_pkg::PH_HI;
                    else if ((in_byte >= qpd_pkg::CH_SPACE && in_byte <= qpd_pkg::CH_TILDE)
                             || in_byte == qpd_pkg::CH_TAB)
                    begin
                        res.emit      = 1'b1;
                        res.out_byte  = in_byte;
                        nxt.out_count = cur.out_count + 16'd1;
                    end
                    else if (in_byte != qpd_pkg::CH_CR && in_byte != qpd_pkg::CH_LF)
                        nxt.error_code = qpd_pkg::ST_INVAL;
                end
            endcase
        end
    end

endmodule

FILE: hw/rtl/quoted_printable_decoder.sv
// Quoted-printable decoder top level: input register, decode step, result register.
// Depends on qpd_pkg and qpd_step.
// A request goes from the input register through qpd_step; an emitted result is registered.
// Throughput: one request per cycle; in_ready falls only while both registers are full
// and the result is not taken.
// Reset: async active low; clears the string state and both valid flags, capacity to 65535.
module quoted_printable_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        is_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        is_final,
    output logic [1:0]  status,
    output logic [15:0] out_length
);

    logic [15:0]          capacity_reg;
    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 is_end_reg;
    qpd_pkg::dec_state_t  state_reg;
    qpd_pkg::dec_state_t  state_next;
    qpd_pkg::dec_result_t step_res;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [7:0]           out_byte_reg;
    logic                 is_final_reg;
    logic [1:0]           status_reg;
    logic [15:0]          out_length_reg;
    logic                 advance;
    logic                 out_free;

    qpd_step u_step (
        .cur      (state_reg),
        .in_byte  (in_byte_reg),
        .is_end   (is_end_reg),
        .capacity (capacity_reg),
        .nxt      (state_next),
        .res      (step_res)
    );

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = in_valid_reg && out_free;
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        if (advance)
            out_valid_next = step_res.emit;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= 16'hFFFF;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
                capacity_reg <= cfg_wdata;
            if (in_ready)
                in_valid_reg <= in_valid;
            out_valid_reg <= out_valid_next;
            if (advance)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_byte_reg <= in_byte;
            is_end_reg  <= is_end;
        end
        if (advance && step_res.emit)
        begin
            out_byte_reg   <= step_res.out_byte;
            is_final_reg   <= step_res.is_final;
            status_reg     <= step_res.status;
            out_length_reg <= step_res.out_length;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign is_final   = is_final_reg;
    assign status     = status_reg;
    assign out_length = out_length_reg;

    // end request clears the string state
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && is_end_reg |=> state_reg.out_count == 16'd0
            && state_reg.error_code == qpd_pkg::ST_OK && state_reg.phase == qpd_pkg::PH_TEXT)
        else $error("string state not cleared after end request");

    // errors stick until the end request
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && !is_end_reg && state_reg.error_code != qpd_pkg::ST_OK
            |=> state_reg.error_code == $past(state_reg.error_code))
        else $error("error code changed before end of string");

    // count moves by one per emitted data byte
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && step_res.emit && !step_res.is_final
            |=> state_reg.out_count == $past(state_reg.out_count) + 16'd1)
        else $error("byte count out of step with emitted data");

    // data results carry no status or length
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !is_final_reg |-> status_reg == qpd_pkg::ST_OK
            && out_length_reg == 16'd0)
        else $error("data result with status or length set");

    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.phase != 2'd3)
        else $error("unused phase code reached");

endmodule
